/* sv/phong_pkg.sv */
// Shared constants, types and table builders for the Phong point light shader.
// Depends on nothing; every other file of the block imports it.
package phong_pkg;

	localparam int POW_TABLE_BITS = 10;
	localparam int TAB_SIZE = 1 << POW_TABLE_BITS;
	localparam int FRAC_BITS = 14;
	localparam logic [14:0] Q14_ONE = 15'd16384;
	localparam int SQRT_STEPS = 17;
	localparam int DIV_STEPS = 15;
	localparam int CFG_ADDR_W = 5;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [1:0] {
		REG_LIGHT_POS,
		REG_LIGHT_COLOR,
		REG_LIGHT_BRIGHT,
		REG_AMBIENT
	} reg_idx_t;

	// Index 0 is x or red, 1 is y or green, 2 is z or blue.
	typedef logic [2:0][15:0] triple_t;

	// Per-item material and geometry that rides along the pipeline.
	typedef struct packed {
		triple_t normal;
		triple_t eye;
		triple_t color;
		logic shadowed;
		logic [15:0] ka;
		logic [15:0] kd;
		logic [15:0] ks;
		logic [15:0] shin;
	} mat_t;

	typedef logic [15:0] log_rom_t [TAB_SIZE];
	typedef logic [30:0] exp_rom_t [TAB_SIZE];

	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] res;
		logic [63:0] rem;
		logic [63:0] bit_v;
		res = '0;
		rem = x;
		bit_v = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + bit_v) begin
				rem = rem - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	// log2(1 + i / TAB_SIZE) in Q.16, one result bit per squaring.
	function automatic log_rom_t build_log_rom();
		log_rom_t rom;
		logic [63:0] y;
		logic [15:0] r;
		for (int i = 0; i < TAB_SIZE; i++) begin
			y = 64'(TAB_SIZE + i) << (30 - POW_TABLE_BITS);
			r = '0;
			for (int k = 1; k <= 16; k++) begin
				y = (y * y) >> 30;
				if (y >= (64'd2 << 30)) begin
					y = y >> 1;
					r[16 - k] = 1'b1;
				end
			end
			rom[i] = r;
		end
		return rom;
	endfunction

	// 2^(-j / TAB_SIZE) in Q.30, built from repeated square roots of two.
	function automatic exp_rom_t build_exp_rom();
		exp_rom_t rom;
		logic [63:0] roots [15];
		logic [63:0] y;
		int m;
		roots[0] = 64'd2 << 30;
		for (int k = 1; k < 15; k++) begin
			roots[k] = isqrt64(roots[k - 1] << 30);
		end
		for (int i = 0; i < TAB_SIZE; i++) begin
			m = TAB_SIZE - i;
			if (m == TAB_SIZE) begin
				y = 64'd2 << 30;
			end else begin
				y = 64'd1 << 30;
				for (int b = 0; b < POW_TABLE_BITS; b++) begin
					if (m[b]) y = (y * roots[POW_TABLE_BITS - b]) >> 30;
				end
			end
			rom[i] = y[31:1];
		end
		return rom;
	endfunction

endpackage

/* sv/phong_geom.sv */
// Light direction unit: difference, squared length, pipelined square root and
// pipelined per-lane divider that normalize the vector to the light. Uses phong_pkg.
module phong_geom (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  phong_pkg::triple_t light_pos,
	input  phong_pkg::triple_t hit,
	input  phong_pkg::mat_t    in_mat,
	output logic              out_valid,
	output phong_pkg::triple_t l_vec,
	output phong_pkg::mat_t    out_mat
);
	import phong_pkg::*;

	localparam int GEOM_LAT = 3 + SQRT_STEPS + DIV_STEPS + 1;
	localparam int SQRT_TOP = 2 * (SQRT_STEPS - 1);

	typedef struct packed {
		logic [33:0] rem;
		logic [34:0] res;
		logic [2:0][15:0] absd;
		logic [2:0] neg;
		mat_t mat;
	} sqrt_stage_t;

	typedef struct packed {
		logic [2:0][29:0] rem;
		logic [2:0][14:0] quo;
		logic [16:0] len;
		logic [2:0] neg;
		mat_t mat;
	} div_stage_t;

	function automatic sqrt_stage_t sqrt_step(input sqrt_stage_t cur, input int k);
		sqrt_stage_t nxt;
		logic [34:0] bit_v;
		logic [34:0] trial;
		nxt = cur;
		bit_v = 35'd1 << (SQRT_TOP - 2 * k);
		trial = cur.res + bit_v;
		if ({1'b0, cur.rem} >= trial) begin
			nxt.rem = cur.rem - trial[33:0];
			nxt.res = (cur.res >> 1) + bit_v;
		end else begin
			nxt.res = cur.res >> 1;
		end
		return nxt;
	endfunction

	function automatic div_stage_t div_step(input div_stage_t cur, input int b);
		div_stage_t nxt;
		logic [31:0] trial;
		nxt = cur;
		trial = 32'(cur.len) << b;
		for (int c = 0; c < 3; c++) begin
			if ({2'b0, cur.rem[c]} >= trial) begin
				nxt.rem[c] = cur.rem[c] - trial[29:0];
				nxt.quo[c][b] = 1'b1;
			end
		end
		return nxt;
	endfunction

	logic [GEOM_LAT-1:0] vld_s;
	logic signed [16:0] d_s1 [3];
	mat_t mat_s1;
	mat_t mat_s2;
	logic [2:0][15:0] absd_s2;
	logic [2:0] neg_s2;
	logic [31:0] sq_s2 [3];
	sqrt_stage_t sq_s [SQRT_STEPS+1];
	div_stage_t dv_init;
	div_stage_t dv_s [1:DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[GEOM_LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				d_s1[c] <= 17'($signed(light_pos[c])) - 17'($signed(hit[c]));
			end
			mat_s1 <= in_mat;
		end
	end

	always_ff @(posedge clk) begin
		logic [16:0] mag;
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				mag = d_s1[c][16] ? 17'(-d_s1[c]) : 17'(d_s1[c]);
				absd_s2[c] <= mag[15:0];
				neg_s2[c] <= d_s1[c][16];
				sq_s2[c] <= 32'(mag[15:0]) * 32'(mag[15:0]);
			end
			mat_s2 <= mat_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s[0].rem <= 34'(sq_s2[0]) + 34'(sq_s2[1]) + 34'(sq_s2[2]);
			sq_s[0].res <= '0;
			sq_s[0].absd <= absd_s2;
			sq_s[0].neg <= neg_s2;
			sq_s[0].mat <= mat_s2;
		end
	end

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		always_ff @(posedge clk) begin
			if (en) sq_s[k+1] <= sqrt_step(sq_s[k], k);
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			dv_init.rem[c] = {sq_s[SQRT_STEPS].absd[c], 14'd0};
		end
		dv_init.quo = '0;
		dv_init.len = sq_s[SQRT_STEPS].res[16:0];
		dv_init.neg = sq_s[SQRT_STEPS].neg;
		dv_init.mat = sq_s[SQRT_STEPS].mat;
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en) dv_s[1] <= div_step(dv_init, DIV_STEPS - 1);
			end
		end else begin : g_rest
			always_ff @(posedge clk) begin
				if (en) dv_s[k+1] <= div_step(dv_s[k], DIV_STEPS - 1 - k);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				if (dv_s[DIV_STEPS].len == '0) begin
					l_vec[c] <= '0;
				end else if (dv_s[DIV_STEPS].neg[c]) begin
					l_vec[c] <= 16'(-{1'b0, dv_s[DIV_STEPS].quo[c]});
				end else begin
					l_vec[c] <= {1'b0, dv_s[DIV_STEPS].quo[c]};
				end
			end
			out_mat <= dv_s[DIV_STEPS].mat;
		end
	end

	assign out_valid = vld_s[GEOM_LAT-1];

	// A component of a normalized vector never exceeds one.
	a_unit_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[GEOM_LAT-2] && dv_s[DIV_STEPS].len != '0 |->
		dv_s[DIV_STEPS].quo[0] <= Q14_ONE && dv_s[DIV_STEPS].quo[1] <= Q14_ONE &&
		dv_s[DIV_STEPS].quo[2] <= Q14_ONE)
		else $error("light vector lane above one");

endmodule

/* sv/phong_refl.sv */
// Dot products: L.N, the reflected light vector R and R.E, with multiply stages
// taking turns with add or subtract stages. Uses phong_pkg.
module phong_refl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  phong_pkg::triple_t l_vec,
	input  phong_pkg::mat_t    in_mat,
	output logic              out_valid,
	output logic signed [31:0] ldn,
	output logic signed [39:0] rde,
	output phong_pkg::mat_t    out_mat
);
	import phong_pkg::*;

	localparam int REFL_LAT = 6;

	logic [REFL_LAT-1:0] vld_s;
	logic signed [15:0] l_s1 [3];
	logic signed [15:0] l_s2 [3];
	logic signed [15:0] l_s3 [3];
	logic signed [31:0] p_s1 [3];
	logic signed [31:0] ldn_s2;
	logic signed [31:0] ldn_s3;
	logic signed [31:0] ldn_s4;
	logic signed [31:0] ldn_s5;
	logic signed [47:0] t_s3 [3];
	logic signed [21:0] r_s4 [3];
	logic signed [37:0] m_s5 [3];
	mat_t mat_s1;
	mat_t mat_s2;
	mat_t mat_s3;
	mat_t mat_s4;
	mat_t mat_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[REFL_LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				l_s1[c] <= $signed(l_vec[c]);
				p_s1[c] <= $signed(l_vec[c]) * $signed(in_mat.normal[c]);
				l_s2[c] <= l_s1[c];
				l_s3[c] <= l_s2[c];
				t_s3[c] <= 48'(ldn_s2) * 48'($signed(mat_s2.normal[c]));
				r_s4[c] <= 22'(t_s3[c] >>> 27) - 22'(l_s3[c]);
				m_s5[c] <= 38'(r_s4[c]) * 38'($signed(mat_s4.eye[c]));
			end
			ldn_s2 <= p_s1[0] + p_s1[1] + p_s1[2];
			ldn_s3 <= ldn_s2;
			ldn_s4 <= ldn_s3;
			ldn_s5 <= ldn_s4;
			ldn <= ldn_s5;
			rde <= 40'(m_s5[0]) + 40'(m_s5[1]) + 40'(m_s5[2]);
			mat_s1 <= in_mat;
			mat_s2 <= mat_s1;
			mat_s3 <= mat_s2;
			mat_s4 <= mat_s3;
			mat_s5 <= mat_s4;
			out_mat <= mat_s5;
		end
	end

	assign out_valid = vld_s[REFL_LAT-1];

endmodule

/* sv/phong_pow.sv */
// Specular factor (R.E)^shininess through log2 and exp2 ROMs with registered reads.
// Uses phong_pkg for the table builders and constants.
module phong_pow (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic signed [31:0] in_ldn,
	input  logic signed [39:0] rde,
	input  phong_pkg::mat_t    in_mat,
	output logic              out_valid,
	output logic signed [31:0] ldn,
	output logic              rde_pos,
	output logic [14:0]       factor,
	output phong_pkg::mat_t    out_mat
);
	import phong_pkg::*;

	localparam int POW_LAT = 7;
	localparam log_rom_t LOG_ROM = build_log_rom();
	localparam exp_rom_t EXP_ROM = build_exp_rom();

	logic [POW_LAT-1:0] vld_s;
	mat_t mat_s [1:POW_LAT-1];
	logic signed [31:0] ldn_s [1:POW_LAT-1];
	logic [POW_LAT-1:1] pos_s;
	logic [POW_LAT-1:1] sat_s;
	logic [POW_LAT-1:1] zero_s;
	logic [13:0] x_s1;
	logic [3:0] p_s2;
	logic [3:0] p_s3;
	logic [POW_TABLE_BITS-1:0] idx_s2;
	logic [15:0] lg_rd_s3;
	logic [19:0] lg_s4;
	logic [27:0] e_s5;
	logic [30:0] exp_s6;
	logic [3:0] n_s6;
	logic big_s6;
	logic [3:0] p_c;
	logic [13:0] frac_c;
	logic [30:0] pow_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[POW_LAT-2:0], in_valid};
		end
	end

	// Carry the side data and range flags down the stages.
	always_ff @(posedge clk) begin
		if (en) begin
			mat_s[1] <= in_mat;
			ldn_s[1] <= in_ldn;
			pos_s[1] <= !rde[39] && rde != '0;
			sat_s[1] <= |rde[39:28];
			zero_s[1] <= rde[39:14] == '0;
			for (int k = 2; k < POW_LAT; k++) begin
				mat_s[k] <= mat_s[k-1];
				ldn_s[k] <= ldn_s[k-1];
				pos_s[k] <= pos_s[k-1];
				sat_s[k] <= sat_s[k-1];
				zero_s[k] <= zero_s[k-1];
			end
			x_s1 <= rde[27:14];
		end
	end

	// Leading one and mantissa fraction of the base.
	always_comb begin
		p_c = '0;
		for (int i = 0; i < FRAC_BITS; i++) begin
			if (x_s1[i]) p_c = 4'(i);
		end
		frac_c = x_s1 << (4'(FRAC_BITS) - p_c);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= p_c;
			idx_s2 <= frac_c[13 -: POW_TABLE_BITS];
			lg_rd_s3 <= LOG_ROM[idx_s2];
			p_s3 <= p_s2;
			lg_s4 <= {4'(FRAC_BITS) - p_s3, 16'd0} - 20'(lg_rd_s3);
			e_s5 <= 28'((36'(lg_s4) * 36'(mat_s[4].shin)) >> 8);
			exp_s6 <= EXP_ROM[e_s5[15 -: POW_TABLE_BITS]];
			n_s6 <= e_s5[19:16];
			big_s6 <= |e_s5[27:20] || e_s5[19:16] == 4'hF;
		end
	end

	assign pow_c = exp_s6 >> (5'd16 + {1'b0, n_s6});

	always_ff @(posedge clk) begin
		if (en) begin
			if (!pos_s[POW_LAT-1]) begin
				factor <= '0;
			end else if (sat_s[POW_LAT-1]) begin
				factor <= Q14_ONE;
			end else if (zero_s[POW_LAT-1]) begin
				factor <= (mat_s[POW_LAT-1].shin == '0) ? Q14_ONE : '0;
			end else if (big_s6) begin
				factor <= '0;
			end else begin
				factor <= pow_c[14:0];
			end
			rde_pos <= pos_s[POW_LAT-1];
			ldn <= ldn_s[POW_LAT-1];
			out_mat <= mat_s[POW_LAT-1];
		end
	end

	assign out_valid = vld_s[POW_LAT-1];

	// Any power of a base below one stays at or below one.
	a_factor_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> factor <= Q14_ONE)
		else $error("specular factor above one");

	// A nonpositive R.E gives no specular factor.
	a_factor_gate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !rde_pos |-> factor == '0)
		else $error("specular factor without positive R.E");

endmodule

/* sv/phong_color.sv */
// Color combiner: ambient, diffuse and specular products per channel, then the
// saturating sum into the output register. Uses phong_pkg.
module phong_color (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic signed [31:0] ldn,
	input  logic              rde_pos,
	input  logic [14:0]       factor,
	input  phong_pkg::mat_t    in_mat,
	input  phong_pkg::triple_t light_color,
	input  logic [15:0]       brightness,
	input  phong_pkg::triple_t ambient,
	output logic              out_valid,
	output phong_pkg::triple_t rgb
);
	import phong_pkg::*;

	localparam int COLOR_LAT = 4;

	logic [COLOR_LAT-1:0] vld_s;
	logic [17:0] a1_s1 [3];
	logic [17:0] e1_s1 [3];
	logic [17:0] s1_s1 [3];
	logic [18:0] sc_s1;
	logic [18:0] sc_s2;
	logic [14:0] fac_s1;
	logic [14:0] fac_s2;
	logic [15:0] kd_s1;
	logic [15:0] ks_s1;
	logic use_d_s1;
	logic use_d_s2;
	logic use_s_s1;
	logic use_s_s2;
	logic [19:0] amb_s2 [3];
	logic [19:0] amb_s3 [3];
	logic [19:0] e2_s2 [3];
	logic [19:0] s2_s2 [3];
	logic [24:0] dif_s3 [3];
	logic [20:0] spec_s3 [3];
	logic [26:0] total_c [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[COLOR_LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				a1_s1[c] <= 18'((32'(in_mat.color[c]) * 32'(in_mat.ka)) >> FRAC_BITS);
				e1_s1[c] <= 18'((32'(in_mat.color[c]) * 32'(light_color[c])) >> FRAC_BITS);
				s1_s1[c] <= 18'((32'(light_color[c]) * 32'(brightness)) >> FRAC_BITS);
				amb_s2[c] <= 20'((34'(a1_s1[c]) * 34'(ambient[c])) >> FRAC_BITS);
				e2_s2[c] <= 20'((34'(e1_s1[c]) * 34'(kd_s1)) >> FRAC_BITS);
				s2_s2[c] <= 20'((34'(s1_s1[c]) * 34'(ks_s1)) >> FRAC_BITS);
				amb_s3[c] <= amb_s2[c];
				dif_s3[c] <= use_d_s2 ?
					25'((39'(e2_s2[c]) * 39'(sc_s2)) >> FRAC_BITS) : '0;
				spec_s3[c] <= use_s_s2 ?
					21'((35'(s2_s2[c]) * 35'(fac_s2)) >> FRAC_BITS) : '0;
				rgb[c] <= (|total_c[c][26:16]) ? '1 : total_c[c][15:0];
			end
			sc_s1 <= 19'((33'(ldn[30:14]) * 33'(brightness)) >> FRAC_BITS);
			sc_s2 <= sc_s1;
			fac_s1 <= factor;
			fac_s2 <= fac_s1;
			kd_s1 <= in_mat.kd;
			ks_s1 <= in_mat.ks;
			use_d_s1 <= !in_mat.shadowed && !ldn[31];
			use_s_s1 <= !in_mat.shadowed && rde_pos;
			use_d_s2 <= use_d_s1;
			use_s_s2 <= use_s_s1;
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			total_c[c] = 27'(amb_s3[c]) + 27'(dif_s3[c]) + 27'(spec_s3[c]);
		end
	end

	assign out_valid = vld_s[COLOR_LAT-1];

endmodule

/* sv/phong_point_light_shader_top.sv */
// Top level of the Phong point light shader: configuration registers, input skid
// register and the geometry, reflection, power and color pipelines. Uses phong_pkg.
//
// Usage: each input transfer carries one shading point (hit position, unit normal,
// unit eye vector, shadow flag, surface color, material coefficients, shininess).
// Each one produces exactly one output transfer with the shaded red, green and blue
// channels, in input order. Both channels use valid and stall; a transfer takes place
// on a rising edge where valid is high and stall is low.
// The datapath is a 53-register pipeline with every stage doing one step: a 17-stage
// square root and a 15-stage divider set most of the depth. With no stall at the
// output, one point is taken every cycle.
// When the receiver stalls a valid result, the whole pipeline holds; one more input
// transfer is still taken into a skid register, after which stall is raised toward
// the sender until the pipeline moves again. Nothing is lost or repeated.
// The APB-style configuration port holds the light position, light color, light
// brightness and scene ambient color at byte addresses 0, 8, 16 and 24; writes belong
// in idle periods. Reset clears the pipeline valid bits and the skid valid bit, sets
// the brightness to one and the other registers to zero.
module phong_point_light_shader_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [phong_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [phong_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [phong_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [47:0]                     hit_position,
	input  logic [47:0]                     surface_normal,
	input  logic [47:0]                     eye_vector,
	input  logic                            shadowed,
	input  logic [47:0]                     surface_color,
	input  logic [15:0]                     ambient_coef,
	input  logic [15:0]                     diffuse_coef,
	input  logic [15:0]                     specular_coef,
	input  logic [15:0]                     shininess,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [15:0]                     out_red,
	output logic [15:0]                     out_green,
	output logic [15:0]                     out_blue
);
	import phong_pkg::*;

	triple_t light_pos_q;
	triple_t light_color_q;
	logic [15:0] brightness_q;
	triple_t ambient_q;
	reg_idx_t reg_idx;
	logic cfg_wr;

	logic en;
	logic skid_v_q;
	triple_t skid_hit_q;
	mat_t skid_mat_q;
	mat_t port_mat;
	mat_t src_mat;
	triple_t src_hit;
	logic src_valid;

	logic geom_valid;
	triple_t geom_l;
	mat_t geom_mat;
	logic refl_valid;
	logic signed [31:0] refl_ldn;
	logic signed [39:0] refl_rde;
	mat_t refl_mat;
	logic pow_valid;
	logic signed [31:0] pow_ldn;
	logic pow_rpos;
	logic [14:0] pow_factor;
	mat_t pow_mat;
	triple_t rgb;

	// Configuration port. pready is held high, so no access phase is extended.
	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_pos_q <= '0;
			light_color_q <= '0;
			brightness_q <= 16'(Q14_ONE);
			ambient_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_LIGHT_POS:    light_pos_q <= pwdata[47:0];
				REG_LIGHT_COLOR:  light_color_q <= pwdata[47:0];
				REG_LIGHT_BRIGHT: brightness_q <= pwdata[15:0];
				REG_AMBIENT:      ambient_q <= pwdata[47:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_LIGHT_POS:    prdata = CFG_DATA_W'(light_pos_q);
			REG_LIGHT_COLOR:  prdata = CFG_DATA_W'(light_color_q);
			REG_LIGHT_BRIGHT: prdata = CFG_DATA_W'(brightness_q);
			REG_AMBIENT:      prdata = CFG_DATA_W'(ambient_q);
		endcase
	end

	// The whole pipeline advances unless a finished result is being held back.
	assign en = !(out_valid && out_stall);

	always_comb begin
		port_mat.normal = surface_normal;
		port_mat.eye = eye_vector;
		port_mat.color = surface_color;
		port_mat.shadowed = shadowed;
		port_mat.ka = ambient_coef;
		port_mat.kd = diffuse_coef;
		port_mat.ks = specular_coef;
		port_mat.shin = shininess;
	end

	// The skid register catches one transfer taken while the pipeline is frozen,
	// and it feeds the pipeline ahead of the port once things move again.
	assign in_stall = skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (en) begin
			skid_v_q <= 1'b0;
		end else if (in_valid && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && in_valid && !skid_v_q) begin
			skid_hit_q <= hit_position;
			skid_mat_q <= port_mat;
		end
	end

	assign src_valid = skid_v_q || in_valid;
	assign src_hit = skid_v_q ? skid_hit_q : hit_position;
	assign src_mat = skid_v_q ? skid_mat_q : port_mat;

	phong_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (src_valid),
		.light_pos (light_pos_q),
		.hit       (src_hit),
		.in_mat    (src_mat),
		.out_valid (geom_valid),
		.l_vec     (geom_l),
		.out_mat   (geom_mat)
	);

	phong_refl u_refl (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (geom_valid),
		.l_vec     (geom_l),
		.in_mat    (geom_mat),
		.out_valid (refl_valid),
		.ldn       (refl_ldn),
		.rde       (refl_rde),
		.out_mat   (refl_mat)
	);

	phong_pow u_pow (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (refl_valid),
		.in_ldn    (refl_ldn),
		.rde       (refl_rde),
		.in_mat    (refl_mat),
		.out_valid (pow_valid),
		.ldn       (pow_ldn),
		.rde_pos   (pow_rpos),
		.factor    (pow_factor),
		.out_mat   (pow_mat)
	);

	phong_color u_color (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (pow_valid),
		.ldn         (pow_ldn),
		.rde_pos     (pow_rpos),
		.factor      (pow_factor),
		.in_mat      (pow_mat),
		.light_color (light_color_q),
		.brightness  (brightness_q),
		.ambient     (ambient_q),
		.out_valid   (out_valid),
		.rgb         (rgb)
	);

	assign out_red = rgb[0];
	assign out_green = rgb[1];
	assign out_blue = rgb[2];

	// A transfer taken while the pipeline is frozen must fill the skid register.
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !en |=> in_stall)
		else $error("input transfer during freeze not held in skid register");

	// Once the pipeline moves, the skid register hands its item on at once.
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && en |=> !skid_v_q)
		else $error("skid register not drained");

endmodule
